### rtl/utt_pkg.sv
// ----------------------------------------------------------------------------
// utt_pkg
// Shared types for the UTF-8 to UTF-16LE transcoder: channel payloads and the
// command record passed from the decoder to the byte serializer.
// ----------------------------------------------------------------------------
package utt_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_text;
  } out_item_t;

  // One decoded code point (or a bare end marker), ready to be serialized.
  // bytes[0] goes out first; last_idx is the index of the final byte.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            data;
    logic            eot;
  } cmd_t;

  localparam logic [1:0] IDX_MARKER = 2'd0;
  localparam logic [1:0] IDX_UNIT   = 2'd1;
  localparam logic [1:0] IDX_PAIR   = 2'd3;

  localparam logic [20:0] BMP_MAX    = 21'h00FFFF;
  localparam logic [20:0] PLANE1     = 21'h010000;
  localparam logic [15:0] HI_SURR    = 16'hD800;
  localparam logic [5:0]  LO_SURR_UP = 6'b110111;

endpackage

### rtl/utf8_to_utf16le_transcoder_core.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16le_transcoder_core
// UTF-8 bytes in, UTF-16LE bytes out, low byte of each unit first.
// Path: command queue, serializer command register, then output register.
// Throughput: one output byte per cycle while commands wait and pop is held, set
//   by the single-byte output register; ASCII gives 2 bytes, a surrogate pair 4.
// Reset: synchronous active-low rst_n clears decoder state, queue and output.
// ----------------------------------------------------------------------------
module utf8_to_utf16le_transcoder_core
  import utt_pkg::*;
#(
  parameter int QDEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  logic      push,
  output logic      full,
  output out_item_t out_data,
  output logic      empty,
  input  logic      pop
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_wr_cmd;
  cmd_t q_rd_cmd;

  utt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .push    (push),
    .full    (full),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_wr_cmd)
  );

  utt_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_cmd),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_cmd),
    .q_empty (q_empty)
  );

  utt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_cmd    (q_rd_cmd),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_data (out_data),
    .empty    (empty),
    .pop      (pop)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("command pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_empty))
    else $error("command popped from empty queue");

  a_marker_is_eot: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_data.byte_valid) |-> out_data.end_of_text)
    else $error("empty marker without end of text");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("output not empty after reset");

endmodule

### rtl/utt_front.sv
// ----------------------------------------------------------------------------
// utt_front
// UTF-8 decoder: takes one byte per transaction, tracks the open sequence and
// pushes a finished code point, split into UTF-16LE bytes, or an end marker.
// ----------------------------------------------------------------------------
module utt_front
  import utt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  in_item_t in_data,
  input  logic     push,
  output logic     full,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  logic [20:0] acc_r, acc_nxt;
  logic [1:0]  rem_r, rem_nxt;
  logic        bad_r, bad_nxt;

  logic        accept;
  logic        emit;
  logic [20:0] cp;
  logic [20:0] v;
  logic [15:0] hi_unit;
  logic [15:0] lo_unit;
  logic [7:0]  b;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign b      = in_data.in_byte;

  always_comb begin
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    bad_nxt = bad_r;
    emit    = 1'b0;
    cp      = acc_r;
    if (rem_r == 2'd0) begin
      if (!b[7]) begin
        emit = 1'b1;
        cp   = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
        acc_nxt = {16'd0, b[4:0]};
        rem_nxt = 2'd1;
        bad_nxt = 1'b0;
      end else if (b[7:4] == 4'b1110) begin
        acc_nxt = {17'd0, b[3:0]};
        rem_nxt = 2'd2;
        bad_nxt = 1'b0;
      end else if (b[7:3] == 5'b11110) begin
        acc_nxt = {18'd0, b[2:0]};
        rem_nxt = 2'd3;
        bad_nxt = 1'b0;
      end
    end else begin
      if (b[7:6] != 2'b10) begin
        bad_nxt = 1'b1;
      end else if (!bad_r) begin
        acc_nxt = {acc_r[14:0], b[5:0]};
      end
      rem_nxt = rem_r - 2'd1;
      emit    = (rem_nxt == 2'd0) && !bad_nxt;
      cp      = acc_nxt;
    end
    // end of text drops any open sequence
    if (in_data.in_last) begin
      acc_nxt = '0;
      rem_nxt = 2'd0;
      bad_nxt = 1'b0;
    end
  end

  // surrogate split; values past the last plane run the high unit into the low-surrogate range
  assign v       = cp - PLANE1;
  assign hi_unit = HI_SURR + {5'd0, v[20:10]};
  assign lo_unit = {LO_SURR_UP, v[9:0]};

  always_comb begin
    q_cmd.eot = in_data.in_last;
    if (!emit) begin
      q_cmd.bytes    = '0;
      q_cmd.last_idx = IDX_MARKER;
      q_cmd.data     = 1'b0;
    end else if (cp <= BMP_MAX) begin
      q_cmd.bytes    = {16'd0, cp[15:8], cp[7:0]};
      q_cmd.last_idx = IDX_UNIT;
      q_cmd.data     = 1'b1;
    end else begin
      q_cmd.bytes    = {lo_unit[15:8], lo_unit[7:0], hi_unit[15:8], hi_unit[7:0]};
      q_cmd.last_idx = IDX_PAIR;
      q_cmd.data     = 1'b1;
    end
  end

  assign q_push = accept && (emit || in_data.in_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      rem_r <= 2'd0;
      bad_r <= 1'b0;
    end else if (accept) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
      bad_r <= bad_nxt;
    end
  end

endmodule

### rtl/utt_fifo.sv
// ----------------------------------------------------------------------------
// utt_fifo
// Short command queue between the decoder and the serializer.
// ----------------------------------------------------------------------------
module utt_fifo
  import utt_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic q_full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic q_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == CNT_FULL);
  assign q_empty = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### rtl/utt_back.sv
// ----------------------------------------------------------------------------
// utt_back
// Serializer: takes commands from the queue and sends their bytes one per
// cycle into the output register while the receiver keeps popping.
// ----------------------------------------------------------------------------
module utt_back
  import utt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      q_cmd,
  input  logic      q_empty,
  output logic      q_pop,
  output out_item_t out_data,
  output logic      empty,
  input  logic      pop
);

  cmd_t       cur_r;
  logic       cur_valid_r, cur_valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  out_item_t  out_r;
  logic       out_valid_r, out_valid_nxt;

  logic       out_load;
  logic       cur_done;

  assign out_load = cur_valid_r && (!out_valid_r || pop);
  assign cur_done = out_load && (idx_r == cur_r.last_idx);
  assign q_pop    = !q_empty && (!cur_valid_r || cur_done);

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      idx_nxt       = 2'd0;
    end else if (cur_done) begin
      cur_valid_nxt = 1'b0;
    end else if (out_load) begin
      idx_nxt = idx_r + 2'd1;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_cmd;
    end
    if (out_load) begin
      out_r.out_byte    <= cur_r.bytes[idx_r];
      out_r.byte_valid  <= cur_r.data;
      out_r.end_of_text <= cur_r.eot && (idx_r == cur_r.last_idx);
    end
  end

  assign out_data = out_r;
  assign empty    = !out_valid_r;

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for utf8_to_utf16le_transcoder_core. A table of directed
// byte sequences runs first: ASCII extremes, each lead length, a code point
// above the valid range, stray and invalid leads, a bad continuation, a
// truncated text and the empty end marker. A random mix of mostly well-formed
// sequences follows. A behavioral decoder predicts UTF-16LE bytes not typed
// into the table; results are checked in order. Both sides idle at random. The
// receiver holds off long enough to fill the core; the sender drains it once.
// ----------------------------------------------------------------------------
module tb
  import utt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT     = 200000;
  localparam int HOLD_CYC  = 60;
  localparam int RAND_MIN  = 85;
  localparam int DIR_ROWS  = 25;

  localparam out_item_t END_MARK = '{out_byte: 8'h00, byte_valid: 1'b0, end_of_text: 1'b1};
  localparam out_item_t NO_OUT   = '0;

  typedef struct packed {
    logic [7:0]      b;
    logic            last;
    logic            known;  // expected results typed into the row
    logic [1:0]      nwant;
    out_item_t [1:0] want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  in_item_t  in_data = '0;
  logic      push = 1'b0;
  logic      full;
  out_item_t out_data;
  logic      empty;
  logic      pop = 1'b0;

  // decoder state mirrored by the predictor
  logic [20:0] acc_cp;
  logic [1:0]  cont_left;
  logic        seq_bad;

  out_item_t   batch[$];
  out_item_t   utf16_q[$];
  dir_row_t    dir_tab[DIR_ROWS];

  int  errors = 0;
  int  cycles = 0;
  int  bytes_in = 0;
  int  results_ok = 0;
  int  eot_seen = 0;
  int  full_cycles = 0;
  bit  no_idle = 1'b0;
  bit  hold_req = 1'b0;

  utf8_to_utf16le_transcoder_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .push    (push),
    .full    (full),
    .out_data(out_data),
    .empty   (empty),
    .pop     (pop)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("utf8_to_utf16le_transcoder_core regression: fail");
      $finish;
    end
  end

  function automatic out_item_t dbyte(logic [7:0] b, logic eot);
    return '{out_byte: b, byte_valid: 1'b1, end_of_text: eot};
  endfunction

  function automatic dir_row_t mk(logic [7:0] b, logic last, logic known, logic [1:0] n,
                                  out_item_t w0, out_item_t w1);
    return '{b: b, last: last, known: known, nwant: n, want: {w1, w0}};
  endfunction

  task automatic emit_cp(input logic [20:0] cp);
    logic [20:0] v;
    logic [15:0] hi, lo;
    if (cp <= 21'h00FFFF) begin
      batch = {batch, dbyte(cp[7:0], 1'b0)};
      batch = {batch, dbyte(cp[15:8], 1'b0)};
    end else begin
      v  = cp - 21'h010000;
      hi = 16'hD800 + {5'b0, v[20:10]};
      lo = 16'hDC00 + {6'b0, v[9:0]};
      batch = {batch, dbyte(hi[7:0], 1'b0)};
      batch = {batch, dbyte(hi[15:8], 1'b0)};
      batch = {batch, dbyte(lo[7:0], 1'b0)};
      batch = {batch, dbyte(lo[15:8], 1'b0)};
    end
  endtask

  // Fills batch with the UTF-16LE bytes that one UTF-8 byte produces.
  task automatic predict_utf16(input logic [7:0] b, input logic last);
    batch.delete();
    if (cont_left == 2'd0) begin
      if (!b[7]) begin
        emit_cp({13'b0, b});
      end else if (b[7:5] == 3'b110) begin
        acc_cp = {16'b0, b[4:0]};
        cont_left = 2'd1;
        seq_bad = 1'b0;
      end else if (b[7:4] == 4'b1110) begin
        acc_cp = {17'b0, b[3:0]};
        cont_left = 2'd2;
        seq_bad = 1'b0;
      end else if (b[7:3] == 5'b11110) begin
        acc_cp = {18'b0, b[2:0]};
        cont_left = 2'd3;
        seq_bad = 1'b0;
      end
    end else begin
      if (b[7:6] != 2'b10) seq_bad = 1'b1;
      else if (!seq_bad) acc_cp = {acc_cp[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0 && !seq_bad) emit_cp(acc_cp);
    end
    if (last) begin
      acc_cp = '0;
      cont_left = '0;
      seq_bad = 1'b0;
      if (batch.size() > 0) batch[batch.size()-1].end_of_text = 1'b1;
      else batch = {batch, END_MARK};
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push    <= 1'b1;
    in_data <= '{in_byte: b, in_last: last};
    @(posedge clk);
    while (full) begin
      full_cycles++;
      @(posedge clk);
    end
    bytes_in++;
    predict_utf16(b, last);
    if (!typed) utf16_q = {utf16_q, batch};
  endtask

  // One UTF-8 sequence: mostly well formed, some with a bad continuation,
  // some cut short by end of text, plus single noise bytes.
  task automatic send_random_seq();
    logic [7:0] seq[$];
    logic [7:0] v;
    logic       last;
    int         kind, len, cut, bad;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      v = 8'($urandom_range(0, 8'h7F));
      seq = {seq, v};
    end else if (kind < 92) begin
      len = (kind < 55) ? 2 : (kind < 70) ? 3 : (kind < 85) ? 4 : $urandom_range(2, 4);
      case (len)
        2:       v = 8'hC0 | 8'($urandom_range(0, 31));
        3:       v = 8'hE0 | 8'($urandom_range(0, 15));
        default: v = 8'hF0 | 8'($urandom_range(0, 7));
      endcase
      seq = {seq, v};
      repeat (len - 1) begin
        v = 8'h80 | 8'($urandom_range(0, 63));
        seq = {seq, v};
      end
      if (kind >= 85) begin
        bad = $urandom_range(0, 191);
        v = (bad < 128) ? 8'(bad) : 8'(bad + 64);
        seq[$urandom_range(1, len - 1)] = v;
      end
    end else begin
      v = 8'($urandom_range(0, 255));
      seq = {seq, v};
    end
    if (seq.size() > 1 && $urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, seq.size() - 1);
      while (seq.size() > cut) void'(seq.pop_back());
      last = 1'b1;
    end else begin
      last = ($urandom_range(0, 5) == 0);
    end
    foreach (seq[k]) send_byte(seq[k], last && (k == seq.size() - 1), 1'b0);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin : result_side
    int        stall;
    out_item_t want;
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYC) begin
          @(negedge clk);
          pop <= 1'b0;
        end
      end
      stall = no_idle ? 0 : $urandom_range(0, 4);
      repeat (stall) begin
        @(negedge clk);
        pop <= 1'b0;
      end
      @(negedge clk);
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      if (utf16_q.size() == 0) begin
        errors++;
        $error("unexpected result transaction: out_byte %02h valid %0b eot %0b",
               out_data.out_byte, out_data.byte_valid, out_data.end_of_text);
      end else begin
        want = utf16_q.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          errors++;
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_data.out_byte);
        end
        if (out_data.byte_valid !== want.byte_valid) begin
          errors++;
          $error("byte_valid: expected %0b, got %0b", want.byte_valid, out_data.byte_valid);
        end
        if (out_data.end_of_text !== want.end_of_text) begin
          errors++;
          $error("end_of_text: expected %0b, got %0b", want.end_of_text, out_data.end_of_text);
        end
        results_ok++;
        if (want.end_of_text) eot_seen++;
      end
    end
  end

  initial begin : stimulus
    int seqs;
    dir_tab[0]  = mk(8'h00, 1'b0, 1'b1, 2'd2, dbyte(8'h00, 1'b0), dbyte(8'h00, 1'b0));
    dir_tab[1]  = mk(8'h7F, 1'b1, 1'b1, 2'd2, dbyte(8'h7F, 1'b0), dbyte(8'h00, 1'b1));
    // two-byte lead and continuation
    dir_tab[2]  = mk(8'hC3, 1'b0, 1'b1, 2'd0, NO_OUT, NO_OUT);
    dir_tab[3]  = mk(8'hA9, 1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT);
    // three-byte sequence
    dir_tab[4]  = mk(8'hE2, 1'b0, 1'b1, 2'd0, NO_OUT, NO_OUT);
    dir_tab[5]  = mk(8'h82, 1'b0, 1'b1, 2'd0, NO_OUT, NO_OUT);
    dir_tab[6]  = mk(8'hAC, 1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT);
    // four-byte sequence, surrogate pair
    dir_tab[7]  = mk(8'hF0, 1'b0, 1'b1, 2'd0, NO_OUT, NO_OUT);
    dir_tab[8]  = mk(8'h9F, 1'b0, 1'b1, 2'd0, NO_OUT, NO_OUT);
    dir_tab[9]  = mk(8'h98, 1'b0, 1'b1, 2'd0, NO_OUT, NO_OUT);
    dir_tab[10] = mk(8'h80, 1'b0, 1'b0, 2'd0, NO_OUT, NO_OUT);
    // largest accumulator value, beyond the Unicode range, ends the text
    dir_tab[11] = mk(8'hF7, 1'b0, 1'b1, 2'd0, NO_OUT, NO_OUT);
    dir_tab[12] = mk(8'hBF, 1'b0, 1'b1, 2'd0, NO_OUT, NO_OUT);
    dir_tab[13] = mk(8'hBF, 1'b0, 1'b1, 2'd0, NO_OUT, NO_OUT);
    dir_tab[14] = mk(8'hBF, 1'b1, 1'b0, 2'd0, NO_OUT, NO_OUT);
    // stray continuation dropped, invalid lead as last byte gives the marker
    dir_tab[15] = mk(8'h80, 1'b0, 1'b1, 2'd0, NO_OUT, NO_OUT);
    dir_tab[16] = mk(8'hFF, 1'b1, 1'b1, 2'd1, END_MARK, NO_OUT);
    // bad continuation still consumes the declared length
    dir_tab[17] = mk(8'hE2, 1'b0, 1'b1, 2'd0, NO_OUT, NO_OUT);
    dir_tab[18] = mk(8'h41, 1'b0, 1'b1, 2'd0, NO_OUT, NO_OUT);
    dir_tab[19] = mk(8'h82, 1'b0, 1'b1, 2'd0, NO_OUT, NO_OUT);
    // sequence cut off by end of text
    dir_tab[20] = mk(8'hF0, 1'b0, 1'b1, 2'd0, NO_OUT, NO_OUT);
    dir_tab[21] = mk(8'h90, 1'b1, 1'b1, 2'd1, END_MARK, NO_OUT);
    dir_tab[22] = mk(8'hF8, 1'b0, 1'b1, 2'd0, NO_OUT, NO_OUT);
    dir_tab[23] = mk(8'hDF, 1'b0, 1'b1, 2'd0, NO_OUT, NO_OUT);
    dir_tab[24] = mk(8'hBF, 1'b1, 1'b0, 2'd0, NO_OUT, NO_OUT);

    acc_cp = '0;
    cont_left = '0;
    seq_bad = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].b, dir_tab[i].last, dir_tab[i].known);
      if (dir_tab[i].known)
        for (int k = 0; k < dir_tab[i].nwant; k++) utf16_q = {utf16_q, dir_tab[i].want[k]};
    end

    for (seqs = 0; bytes_in - DIR_ROWS < RAND_MIN; seqs++) begin
      if (seqs == 8) hold_req = 1'b1;
      if (seqs == 15) begin
        @(negedge clk);
        push <= 1'b0;
        while (utf16_q.size() != 0) @(posedge clk);
      end
      no_idle = (seqs >= 18 && seqs < 28);
      send_random_seq();
    end

    @(negedge clk);
    push <= 1'b0;
    while (utf16_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("covered %0d input bytes (%0d directed), %0d result bytes, %0d end-of-text results",
             bytes_in, DIR_ROWS, results_ok, eot_seen);
    $display("input stalled by a full core for %0d cycles", full_cycles);
    if (errors == 0) begin
      $display("utf8_to_utf16le_transcoder_core regression: pass");
    end else begin
      $display("utf8_to_utf16le_transcoder_core regression: fail");
    end
    $finish;
  end

endmodule

### utf8_to_utf16le_transcoder_core.f
rtl/utt_pkg.sv
rtl/utt_front.sv
rtl/utt_fifo.sv
rtl/utt_back.sv
rtl/utf8_to_utf16le_transcoder_core.sv
tb/tb.sv
